### rtl/cbf_pkg.sv
// Shared types, constants and the quarter-round helper of the ChaCha block function unit.
package cbf_pkg;

	localparam int WORD_W    = 32;
	localparam int BLK_WORDS = 16;
	localparam int IDX_W     = 4;
	localparam int RND_W     = 4;

	localparam logic [RND_W-1:0] RND_RESET = 4'd10;

	// One complete input block as handed from the loader to the round engine.
	typedef struct packed {
		logic [BLK_WORDS-1:0][WORD_W-1:0] words;
		logic [RND_W-1:0]                 rounds;
	} blk_t;

	// Queue status seen by the two sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// The four words of one quarter-round lane.
	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
	} quad_t;

	// Half of a quarter round: rotations 16/12 for the first half, 8/7 for the second.
	function automatic quad_t qr_half(
		input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b,
		input logic [WORD_W-1:0] c,
		input logic [WORD_W-1:0] d,
		input logic              second
	);
		quad_t             r;
		logic [WORD_W-1:0] t;
		r.a = a + b;
		t   = d ^ r.a;
		r.d = second ? {t[23:0], t[31:24]} : {t[15:0], t[31:16]};
		r.c = c + r.d;
		t   = b ^ r.c;
		r.b = second ? {t[24:0], t[31:25]} : {t[19:0], t[31:20]};
		return r;
	endfunction

endpackage

### rtl/cbf_loader.sv
// Front end: collects sixteen input words and the round count into one queue entry.
module cbf_loader (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [cbf_pkg::WORD_W-1:0]        state_word,
	input  logic                              cfg_valid,
	input  logic [cbf_pkg::RND_W-1:0]         double_rounds,
	input  cbf_pkg::q_stat_t                  q_stat,
	output logic                              push,
	output cbf_pkg::blk_t                     push_blk
);

	localparam logic [cbf_pkg::IDX_W-1:0] LAST_IDX = cbf_pkg::IDX_W'(cbf_pkg::BLK_WORDS - 1);

	logic [cbf_pkg::WORD_W-1:0] buf_q [cbf_pkg::BLK_WORDS-1];
	logic [cbf_pkg::IDX_W-1:0]  cnt_q;
	logic [cbf_pkg::RND_W-1:0]  rounds_q;
	logic                       accept;

	// Stall only the closing word, and only while the queue has no room.
	assign in_stall = (cnt_q == LAST_IDX) && q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign push     = accept && (cnt_q == LAST_IDX);

	always_comb begin
		for (int i = 0; i < cbf_pkg::BLK_WORDS - 1; i++) begin
			push_blk.words[i] = buf_q[i];
		end
		push_blk.words[cbf_pkg::BLK_WORDS-1] = state_word;
		push_blk.rounds                      = rounds_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rounds_q <= cbf_pkg::RND_RESET;
		end else begin
			if (cfg_valid) begin
				rounds_q <= double_rounds;
			end
			if (accept) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cnt_q != LAST_IDX)) begin
			buf_q[cnt_q] <= state_word;
		end
	end

endmodule

### rtl/cbf_queue.sv
// Two-entry block queue between the loader and the round engine.
module cbf_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cbf_pkg::blk_t    push_blk,
	input  logic             pop,
	output cbf_pkg::blk_t    pop_blk,
	output cbf_pkg::q_stat_t q_stat
);

	cbf_pkg::blk_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign q_stat.full  = (count_q == 2'd2);
	assign q_stat.empty = (count_q == 2'd0);
	assign pop_blk      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_blk;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full) else $error("block pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty) else $error("block popped from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");

endmodule

### rtl/cbf_core.sv
// Back end: double rounds, feed-forward add and word-by-word output register.
module cbf_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cbf_pkg::q_stat_t            q_stat,
	input  cbf_pkg::blk_t               pop_blk,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [cbf_pkg::WORD_W-1:0]  stream_word,
	output logic [cbf_pkg::IDX_W-1:0]   word_position,
	output logic                        last_word
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	localparam logic [cbf_pkg::IDX_W-1:0] LAST_IDX = cbf_pkg::IDX_W'(cbf_pkg::BLK_WORDS - 1);

	logic [1:0]                 state_q;
	logic [cbf_pkg::WORD_W-1:0] x_q    [cbf_pkg::BLK_WORDS];
	logic [cbf_pkg::WORD_W-1:0] orig_q [cbf_pkg::BLK_WORDS];
	logic [cbf_pkg::WORD_W-1:0] x_nxt  [cbf_pkg::BLK_WORDS];
	logic [cbf_pkg::RND_W-1:0]  rem_q;
	logic [1:0]                 phase_q;
	logic [cbf_pkg::IDX_W-1:0]  idx_q;
	logic                       out_valid_q;
	logic [cbf_pkg::WORD_W-1:0] word_q;
	logic [cbf_pkg::IDX_W-1:0]  pos_q;
	logic                       last_q;
	logic                       adv;

	assign pop = (state_q == ST_IDLE) && !q_stat.empty;
	assign adv = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	assign out_valid     = out_valid_q;
	assign stream_word   = word_q;
	assign word_position = pos_q;
	assign last_word     = last_q;

	// phase bit 1 selects diagonal lanes, bit 0 the second half of the quarter round.
	always_comb begin
		for (int i = 0; i < cbf_pkg::BLK_WORDS; i++) begin
			x_nxt[i] = x_q[i];
		end
		for (int j = 0; j < 4; j++) begin
			logic [1:0]                lane;
			logic [1:0]                off1;
			logic [1:0]                off2;
			logic [1:0]                off3;
			logic [cbf_pkg::IDX_W-1:0] ia;
			logic [cbf_pkg::IDX_W-1:0] ib;
			logic [cbf_pkg::IDX_W-1:0] ic;
			logic [cbf_pkg::IDX_W-1:0] id;
			cbf_pkg::quad_t            q;
			lane = 2'(j);
			off1 = phase_q[1] ? 2'd1 : 2'd0;
			off2 = phase_q[1] ? 2'd2 : 2'd0;
			off3 = phase_q[1] ? 2'd3 : 2'd0;
			ia   = {2'b00, lane};
			ib   = {2'b01, 2'(lane + off1)};
			ic   = {2'b10, 2'(lane + off2)};
			id   = {2'b11, 2'(lane + off3)};
			q    = cbf_pkg::qr_half(x_q[ia], x_q[ib], x_q[ic], x_q[id], phase_q[0]);
			x_nxt[ia] = q.a;
			x_nxt[ib] = q.b;
			x_nxt[ic] = q.c;
			x_nxt[id] = q.d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rem_q       <= '0;
			phase_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						rem_q   <= pop_blk.rounds;
						phase_q <= '0;
						idx_q   <= '0;
						state_q <= (pop_blk.rounds == '0) ? ST_EMIT : ST_ROUND;
					end
				end
				ST_ROUND: begin
					phase_q <= phase_q + 1'b1;
					if (phase_q == 2'd3) begin
						rem_q <= rem_q - 1'b1;
						if (rem_q == cbf_pkg::RND_W'(1)) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (adv) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == LAST_IDX) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < cbf_pkg::BLK_WORDS; i++) begin
				x_q[i]    <= pop_blk.words[i];
				orig_q[i] <= pop_blk.words[i];
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < cbf_pkg::BLK_WORDS; i++) begin
				x_q[i] <= x_nxt[i];
			end
		end
		if (adv) begin
			word_q <= x_q[idx_q] + orig_q[idx_q];
			pos_q  <= idx_q;
			last_q <= (idx_q == LAST_IDX);
		end
	end

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (pos_q == LAST_IDX)) else $error("last flag off word 15");
	a_round_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rem_q != '0)) else $error("round state with no rounds left");
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (idx_q == LAST_IDX)) |=> (state_q == ST_IDLE && out_valid_q && last_q))
		else $error("block end not followed by idle");

endmodule

### rtl/chacha20_block_function_unit.sv
// Top level of the ChaCha block function unit: loader, block queue and round engine.
//
//  Channel | Handshake             | Payload                                 | Direction
//  --------+-----------------------+-----------------------------------------+----------
//  input   | in_valid / in_stall   | state_word[31:0]                        | in
//  output  | out_valid / out_stall | stream_word[31:0], word_position[3:0],  | out
//          |                       | last_word                               |
//  config  | cfg_valid / cfg_ready | double_rounds[3:0]                      | in
//
//  Flow: the loader takes one input word per cycle, 16 per block, while in_stall is low.
//  The round engine does half a quarter round on all four lanes per cycle, column lanes
//  then diagonal lanes in each double round, and the 16 output words then leave at one
//  per cycle while out_stall is low. The engine finishes a block before it pops the next,
//  while loading of the next block overlaps with it through the two-entry block queue.
//  Reset: arst_n clears the load count, queue pointers, engine state and output valid;
//  double_rounds resets to 10 (ChaCha20). The word buffers need no reset.
//  Stalls: in_stall rises only on the sixteenth word of a block while the queue is full;
//  out_stall holds the output register and the engine stops emitting until it drains.
//  cfg_ready is always high; the round count is captured per block at its last word.
module chacha20_block_function_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// input words
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [cbf_pkg::WORD_W-1:0]  state_word,
	// output words
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [cbf_pkg::WORD_W-1:0]  stream_word,
	output logic [cbf_pkg::IDX_W-1:0]   word_position,
	output logic                        last_word,
	// configuration
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [cbf_pkg::RND_W-1:0]   double_rounds
);

	cbf_pkg::q_stat_t q_stat;
	cbf_pkg::blk_t    push_blk;
	cbf_pkg::blk_t    pop_blk;
	logic             push;
	logic             pop;

	// The round count register always takes a write request at once.
	assign cfg_ready = 1'b1;

	// Front: gather words, push one block per sixteenth word.
	cbf_loader u_loader (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.state_word    (state_word),
		.cfg_valid     (cfg_valid),
		.double_rounds (double_rounds),
		.q_stat        (q_stat),
		.push          (push),
		.push_blk      (push_blk)
	);

	// Decouple: hold up to two complete blocks.
	cbf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_blk (push_blk),
		.pop      (pop),
		.pop_blk  (pop_blk),
		.q_stat   (q_stat)
	);

	// Back: run the rounds, add the input block, emit words in order.
	cbf_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.pop_blk       (pop_blk),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.stream_word   (stream_word),
		.word_position (word_position),
		.last_word     (last_word)
	);

endmodule
